// ===== hw/rtl/i2cbm_pkg.sv =====
// Shared types and constants of the I2C bit-level master core.
// Holds the phase and command codes, the item structs and the sequencer state struct.
// Depends on nothing.
package i2cbm_pkg;

  // Sequencer phases.
  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_ST_A   = 5'd1;
  localparam logic [4:0] PH_ST_B   = 5'd2;
  localparam logic [4:0] PH_ST_C   = 5'd3;
  localparam logic [4:0] PH_BIT_LO = 5'd4;
  localparam logic [4:0] PH_BIT_HI = 5'd5;
  localparam logic [4:0] PH_TAIL   = 5'd6;
  localparam logic [4:0] PH_SP_A   = 5'd7;
  localparam logic [4:0] PH_SP_B   = 5'd8;
  localparam logic [4:0] PH_SP_C   = 5'd9;

  // Command codes.
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;
  localparam logic [2:0] OP_PROBE     = 3'd6;

  // Configuration register indexes.
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_HOLD        = 1'b1;

  // Bits of one byte; the acknowledge slot comes after them.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       no_ack;
  } res_item_t;

  typedef struct packed {
    logic [4:0] phase;
    logic [2:0] op;
    logic [7:0] shift_byte;
    logic [3:0] bit_index;
    logic [7:0] tick_counter;
    logic       scl;
    logic       sda;
    logic       probe_ack;
    logic [7:0] read_reg;
  } seq_state_t;

endpackage

// ===== hw/rtl/i2cbm_step.sv =====
// Next-state and result logic for one tick of the I2C bit sequencer.
// Purely combinational; uses i2cbm_pkg for codes and structs.
module i2cbm_step (
  input  i2cbm_pkg::seq_state_t state_i,
  input  i2cbm_pkg::cmd_item_t  item_i,
  input  logic [7:0]            half_period_i,
  input  logic [7:0]            hold_i,
  output i2cbm_pkg::seq_state_t state_o,
  output i2cbm_pkg::res_item_t  res_o
);
  import i2cbm_pkg::*;

  seq_state_t s;
  logic       busy;
  logic       done;
  logic       is_read;
  logic       bit_lvl;
  logic [7:0] len_raw;
  logic [8:0] len;
  logic [8:0] tick_next;

  always_comb begin
    s    = state_i;
    busy = 1'b0;
    done = 1'b0;

    // Take a new command only while idle; unknown codes are ignored.
    if (s.phase == PH_IDLE && item_i.command >= OP_START && item_i.command <= OP_PROBE) begin
      s.op           = item_i.command;
      s.bit_index    = 4'd0;
      s.tick_counter = 8'd0;
      s.shift_byte   = (item_i.command == OP_READ_ACK || item_i.command == OP_READ_NACK)
                       ? 8'd0 : item_i.data_byte;
      if (item_i.command == OP_STOP) begin
        s.phase = PH_SP_A;
      end else if (item_i.command == OP_START || item_i.command == OP_PROBE) begin
        s.phase = PH_ST_A;
      end else begin
        s.phase = PH_BIT_LO;
      end
    end

    is_read = (s.op == OP_READ_ACK) || (s.op == OP_READ_NACK);

    // Level of the current data bit: payload MSB first, then the acknowledge slot.
    if (s.bit_index < BYTE_BITS) begin
      bit_lvl = is_read ? 1'b1 : s.shift_byte[3'd7 - s.bit_index[2:0]];
    end else begin
      bit_lvl = (s.op != OP_READ_ACK);
    end

    // Phase length; a zero register value counts as one tick.
    len_raw   = (s.phase == PH_ST_B || s.phase == PH_SP_B) ? hold_i : half_period_i;
    len       = (len_raw == 8'd0) ? 9'd1 : {1'b0, len_raw};
    tick_next = {1'b0, s.tick_counter} + 9'd1;

    if (s.phase != PH_IDLE) begin
      busy = 1'b1;

      // Line levels driven during this phase.
      unique case (s.phase)
        PH_ST_A:   {s.scl, s.sda} = 2'b11;
        PH_ST_B:   {s.scl, s.sda} = 2'b10;
        PH_ST_C:   {s.scl, s.sda} = 2'b00;
        PH_BIT_LO: {s.scl, s.sda} = {1'b0, bit_lvl};
        PH_BIT_HI: {s.scl, s.sda} = {1'b1, bit_lvl};
        PH_TAIL:   {s.scl, s.sda} = {1'b0, s.op != OP_READ_ACK};
        PH_SP_A:   {s.scl, s.sda} = 2'b00;
        PH_SP_B:   {s.scl, s.sda} = 2'b10;
        PH_SP_C:   {s.scl, s.sda} = 2'b11;
        default:   {s.scl, s.sda} = {s.scl, s.sda};
      endcase

      // End of phase: move on, or finish the command.
      if (tick_next >= len) begin
        s.tick_counter = 8'd0;
        unique case (s.phase)
          PH_ST_A: s.phase = PH_ST_B;
          PH_ST_B: s.phase = PH_ST_C;
          PH_ST_C: begin
            if (s.op == OP_PROBE) begin
              s.bit_index = 4'd0;
              s.phase     = PH_BIT_LO;
            end else begin
              done = 1'b1;
            end
          end
          PH_BIT_LO: s.phase = PH_BIT_HI;
          PH_BIT_HI: begin
            if (s.bit_index < BYTE_BITS) begin
              if (is_read) begin
                s.shift_byte = {s.shift_byte[6:0], item_i.sda_in};
              end
              s.bit_index = s.bit_index + 4'd1;
              s.phase     = PH_BIT_LO;
            end else if (s.op == OP_PROBE) begin
              s.probe_ack = item_i.sda_in;
              s.phase     = PH_SP_A;
            end else begin
              s.phase = PH_TAIL;
            end
          end
          PH_TAIL: begin
            if (is_read) begin
              s.read_reg = s.shift_byte;
            end
            done = 1'b1;
          end
          PH_SP_A: s.phase = PH_SP_B;
          PH_SP_B: s.phase = PH_SP_C;
          default: done = 1'b1;
        endcase
        if (done) begin
          s.phase = PH_IDLE;
        end
      end else begin
        s.tick_counter = tick_next[7:0];
      end
    end

    state_o           = s;
    res_o.scl_level   = s.scl;
    res_o.sda_release = s.sda;
    res_o.busy_res    = busy;
    res_o.done_res    = done;
    res_o.read_value  = s.read_reg;
    res_o.no_ack      = s.probe_ack;
  end

endmodule

// ===== hw/rtl/i2cbm_out_reg.sv =====
// Result register with valid/stall handshake for the I2C bit-level master.
// Decouples the result side from the tick side; uses i2cbm_pkg for the result struct.
module i2cbm_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  i2cbm_pkg::res_item_t res_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cbm_pkg::res_item_t out_data_o
);
  import i2cbm_pkg::*;

  logic      valid_q;
  res_item_t data_q;

  // A new result may enter when the register is empty or being emptied now.
  assign room_o = !(valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload register, loaded with each accepted item's result.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/i2c_bit_level_master_core.sv =====
// I2C bit-level master core: one input item is one bus timing tick and yields one result
// item. Depends on i2cbm_pkg, i2cbm_step and i2cbm_out_reg.
//
// Each accepted item is one tick of the bus sequencer and gives exactly one result in the
// next cycle; a new item is accepted in every clock cycle as long as the result register is
// empty or is being emptied, so the rate is one item per cycle, set by the single sequencer
// state register updated on each accepted tick. A command (start, stop, write, read with
// ack or nack, probe) is taken only while the sequencer is idle; SCL half periods and
// start/stop holds last half_period_q and hold_q ticks, zero counted as one. Configuration
// writes are taken at any edge with cfg_we_i high and must only be issued while idle.
module i2c_bit_level_master_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cbm_pkg::cmd_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cbm_pkg::res_item_t  out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [7:0]            cfg_wdata_i
);
  import i2cbm_pkg::*;

  seq_state_t state_q, state_d;
  res_item_t  res;
  logic [7:0] half_period_q;
  logic [7:0] hold_q;
  logic       room;
  logic       in_accept;

  assign in_stall_o = !room;
  assign in_accept  = in_valid_i && room;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= 8'd2;
      hold_q        <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HALF_PERIOD: half_period_q <= cfg_wdata_i;
        REG_HOLD:        hold_q        <= cfg_wdata_i;
        default:         hold_q        <= hold_q;
      endcase
    end
  end

  i2cbm_step u_step (
    .state_i       (state_q),
    .item_i        (in_data_i),
    .half_period_i (half_period_q),
    .hold_i        (hold_q),
    .state_o       (state_d),
    .res_o         (res)
  );

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, op: OP_NONE, shift_byte: 8'd0, bit_index: 4'd0,
                   tick_counter: 8'd0, scl: 1'b1, sda: 1'b1, probe_ack: 1'b0,
                   read_reg: 8'd0};
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  i2cbm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/i2cbm_checker.sv =====
// Port-level assertions for the I2C bit-level master core and the bind that attaches them.
// Depends on i2cbm_pkg and on the ports of i2c_bit_level_master_core.
module i2cbm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input i2cbm_pkg::res_item_t out_data_o
);

  // A finishing tick is always a busy tick.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.busy_res)
    else $error("done without busy");

  // The input side only waits while a result is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // Every accepted tick produces a result on the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick gave no result");

  // A held result does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind i2c_bit_level_master_core i2cbm_checker u_i2cbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== test/tb.sv =====
// Self-checking testbench for the I2C bit-level master core.
// Predicts the SCL/SDA levels and the status of every tick, and drives commands,
// timing settings and random stalls. Depends on i2cbm_pkg and i2c_bit_level_master_core.
module tb;
  import i2cbm_pkg::*;

  // Code 7 has no meaning and must be treated like no command.
  localparam logic [2:0] OP_RESERVED = 3'd7;

  typedef enum {SDA_LOW, SDA_ONE, SDA_RANDOM} sda_mode_e;

  // Tick-level model of the bus sequencer and the store of predicted line states.
  class bus_tick_scoreboard;
    logic [7:0] half_ticks;
    logic [7:0] hold_len;
    logic [4:0] phase;
    logic [2:0] op;
    logic [7:0] shift_reg;
    logic [3:0] bit_idx;
    logic [7:0] tick_cnt;
    logic       scl;
    logic       sda;
    logic       probe_nack;
    logic [7:0] rd_byte;
    res_item_t  expected_lines[$];
    int         mismatches;
    int         failures;

    function new();
      half_ticks = 8'd2;
      hold_len   = 8'd5;
      phase      = PH_IDLE;
      op         = OP_NONE;
      shift_reg  = '0;
      bit_idx    = '0;
      tick_cnt   = '0;
      scl        = 1'b1;
      sda        = 1'b1;
      probe_nack = 1'b0;
      rd_byte    = '0;
      mismatches = 0;
      failures   = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] value);
      if (idx == REG_HALF_PERIOD) begin
        half_ticks = value;
      end else begin
        hold_len = value;
      end
    endfunction

    function bit idle();
      return phase == PH_IDLE;
    endfunction

    function bit is_read();
      return op == OP_READ_ACK || op == OP_READ_NACK;
    endfunction

    // SDA level of the current bit slot; the ninth slot is the acknowledge.
    function logic data_bit();
      if (bit_idx < BYTE_BITS) begin
        if (is_read()) return 1'b1;
        return shift_reg[3'd7 - bit_idx[2:0]];
      end
      return op != OP_READ_ACK;
    endfunction

    // Moves to the next phase; returns 1 when the command has finished.
    function bit step_phase(logic sda_in);
      case (phase)
        PH_ST_A: phase = PH_ST_B;
        PH_ST_B: phase = PH_ST_C;
        PH_ST_C: begin
          if (op != OP_PROBE) return 1'b1;
          bit_idx = '0;
          phase = PH_BIT_LO;
        end
        PH_BIT_LO: phase = PH_BIT_HI;
        PH_BIT_HI: begin
          if (bit_idx < BYTE_BITS) begin
            if (is_read()) shift_reg = {shift_reg[6:0], sda_in};
            bit_idx = bit_idx + 4'd1;
            phase = PH_BIT_LO;
          end else if (op == OP_PROBE) begin
            probe_nack = sda_in;
            phase = PH_SP_A;
          end else begin
            phase = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (is_read()) rd_byte = shift_reg;
          return 1'b1;
        end
        PH_SP_A: phase = PH_SP_B;
        PH_SP_B: phase = PH_SP_C;
        default: return 1'b1;
      endcase
      return 1'b0;
    endfunction

    // Works out the line state of one accepted tick and queues it.
    function void accept_tick(cmd_item_t it);
      res_item_t  res;
      logic [1:0] lines;
      logic [7:0] len;
      logic       busy;
      logic       done;
      busy = 1'b0;
      done = 1'b0;
      if (phase == PH_IDLE && it.command >= OP_START && it.command <= OP_PROBE) begin
        op = it.command;
        bit_idx = '0;
        tick_cnt = '0;
        shift_reg = is_read() ? 8'h00 : it.data_byte;
        if (op == OP_STOP) phase = PH_SP_A;
        else if (op == OP_START || op == OP_PROBE) phase = PH_ST_A;
        else phase = PH_BIT_LO;
      end
      if (phase != PH_IDLE) begin
        busy = 1'b1;
        case (phase)
          PH_ST_A:   lines = 2'b11;
          PH_ST_B:   lines = 2'b10;
          PH_ST_C:   lines = 2'b00;
          PH_BIT_LO: lines = {1'b0, data_bit()};
          PH_BIT_HI: lines = {1'b1, data_bit()};
          PH_TAIL:   lines = {1'b0, op != OP_READ_ACK};
          PH_SP_A:   lines = 2'b00;
          PH_SP_B:   lines = 2'b10;
          PH_SP_C:   lines = 2'b11;
          default:   lines = {scl, sda};
        endcase
        {scl, sda} = lines;
        len = (phase == PH_ST_B || phase == PH_SP_B) ? hold_len : half_ticks;
        if (len == 8'd0) len = 8'd1;
        if (int'(tick_cnt) + 1 >= int'(len)) begin
          tick_cnt = '0;
          if (step_phase(it.sda_in)) begin
            done = 1'b1;
            phase = PH_IDLE;
          end
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end
      res.scl_level   = scl;
      res.sda_release = sda;
      res.busy_res    = busy;
      res.done_res    = done;
      res.read_value  = rd_byte;
      res.no_ack      = probe_nack;
      expected_lines.push_back(res);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_lines(res_item_t got);
      res_item_t exp;
      bit        bad;
      if (expected_lines.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %p", got);
        return;
      end
      exp = expected_lines.pop_front();
      bad = 1'b0;
      if (got.scl_level !== exp.scl_level) bad = 1'b1;
      if (got.sda_release !== exp.sda_release) bad = 1'b1;
      if (got.busy_res !== exp.busy_res) bad = 1'b1;
      if (got.done_res !== exp.done_res) bad = 1'b1;
      if (got.read_value !== exp.read_value) bad = 1'b1;
      if (got.no_ack !== exp.no_ack) bad = 1'b1;
      if (bad) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected scl=%b sda=%b busy=%b done=%b read=%h nack=%b",
                   exp.scl_level, exp.sda_release, exp.busy_res, exp.done_res,
                   exp.read_value, exp.no_ack);
          $display("          actual   scl=%b sda=%b busy=%b done=%b read=%h nack=%b",
                   got.scl_level, got.sda_release, got.busy_res, got.done_res,
                   got.read_value, got.no_ack);
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  cmd_item_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  res_item_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  bit                 idle_on = 1'b1;
  bus_tick_scoreboard sb = new();

  i2c_bit_level_master_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Random back-pressure on the result side.
  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 6);
  end

  // Both handshakes are observed at the rising edge; results are checked before
  // the tick of the same edge is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_lines(out_data_o);
      if (in_valid_i && !in_stall_o) sb.accept_tick(in_data_i);
    end
  end

  function automatic logic pick_sda(sda_mode_e mode);
    if (mode == SDA_LOW) return 1'b0;
    if (mode == SDA_ONE) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  // Presents one tick item, with an occasional gap, and waits until it is taken.
  task automatic send_tick(logic [2:0] cmd, logic [7:0] data, logic sda_lvl);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{command: cmd, data_byte: data, sda_in: sda_lvl};
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Issues one command and keeps ticking with the filler command until it is done.
  task automatic run_cmd(logic [2:0] cmd, logic [7:0] data, sda_mode_e mode,
                         logic [2:0] filler);
    send_tick(cmd, data, pick_sda(mode));
    while (!sb.idle()) send_tick(filler, 8'($urandom), pick_sda(mode));
  endtask

  // Mostly complete commands with random content; busy ticks carry stray commands now and then.
  task automatic random_ticks(int count);
    logic [2:0] cmd;
    int         roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (sb.idle()) begin
        if (roll < 85) cmd = 3'($urandom_range(OP_PROBE, OP_START));
        else if (roll < 93) cmd = OP_NONE;
        else cmd = OP_RESERVED;
      end else begin
        cmd = (roll < 90) ? OP_NONE : 3'($urandom_range(7));
      end
      send_tick(cmd, 8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // Finishes the running command, drains all results, then writes both timing registers.
  task automatic set_timing(logic [7:0] half, logic [7:0] hold);
    while (!sb.idle()) send_tick(OP_NONE, 8'($urandom), 1'($urandom_range(1)));
    in_valid_i <= 1'b0;
    while (sb.expected_lines.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_HALF_PERIOD;
    cfg_wdata_i <= half;
    @(negedge clk_i);
    cfg_index_i <= REG_HOLD;
    cfg_wdata_i <= hold;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(REG_HALF_PERIOD, half);
    sb.write_reg(REG_HOLD, hold);
  endtask

  // Main sequence.
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed commands at the reset timing.
    run_cmd(OP_NONE, 8'h00, SDA_RANDOM, OP_NONE);
    run_cmd(OP_RESERVED, 8'hFF, SDA_RANDOM, OP_NONE);
    run_cmd(OP_START, 8'h00, SDA_RANDOM, OP_WRITE);
    run_cmd(OP_WRITE, 8'hFF, SDA_LOW, OP_NONE);
    run_cmd(OP_WRITE, 8'h00, SDA_ONE, OP_PROBE);
    run_cmd(OP_READ_ACK, 8'h5A, SDA_ONE, OP_NONE);
    run_cmd(OP_READ_NACK, 8'hFF, SDA_LOW, OP_NONE);
    run_cmd(OP_READ_ACK, 8'h00, SDA_RANDOM, OP_START);
    run_cmd(OP_PROBE, 8'hA0, SDA_LOW, OP_NONE);
    run_cmd(OP_PROBE, 8'h5F, SDA_ONE, OP_READ_NACK);
    run_cmd(OP_STOP, 8'h00, SDA_RANDOM, OP_RESERVED);

    set_timing(8'd1, 8'd1);
    random_ticks(60);

    // Zero register values count as one tick.
    set_timing(8'd0, 8'd0);
    random_ticks(50);

    // A stretch with no gaps and no stalls.
    set_timing(8'd3, 8'd2);
    idle_on = 1'b0;
    random_ticks(100);
    idle_on = 1'b1;

    set_timing(8'd1, 8'd255);
    random_ticks(60);

    // Long phase counts at the largest settings.
    set_timing(8'd255, 8'd255);
    random_ticks(50);

    set_timing(8'd2, 8'd3);
    random_ticks(60);

    in_valid_i <= 1'b0;
    while (sb.expected_lines.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    sb.failures += sb.expected_lines.size();
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
